// File: src/dpw_pkg.sv
// Shared constants, codes and controller/datapath interface types for the duplicate packet window.
`default_nettype none
package dpw_pkg;

  // Ring geometry. TABLE_DEPTH is a power of two; slot arithmetic wraps on its low bits.
  localparam int TABLE_DEPTH   = 64;
  localparam int NEWEST_OFFSET = 63;
  localparam int SLOT_W        = $clog2(TABLE_DEPTH);

  localparam int ID_W   = 16;
  localparam int MASK_W = 64;
  localparam int CNT_W  = $clog2(MASK_W);
  localparam int STAT_W = 2;

  localparam logic [STAT_W-1:0] STAT_NEW   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_DUP   = 2'd1;
  localparam logic [STAT_W-1:0] STAT_STALE = 2'd2;

  typedef struct packed {
    logic capture;   // latch the accepted beat
    logic evaluate;  // window compare, slide or rebase, table read
    logic check;     // mask test and write back
    logic publish;   // load the result register
  } dpw_cmd_t;

  typedef struct packed {
    logic stale;     // block id at or before the oldest id
  } dpw_sts_t;

endpackage
`default_nettype wire

// File: src/dpw_ctrl.sv
// Sequencer for the duplicate packet window: handshakes and datapath commands.
`default_nettype none
module dpw_ctrl
  import dpw_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     pkt_valid,
  output logic          pkt_stall,
  output logic          res_valid,
  input  wire logic     res_stall,
  input  wire dpw_sts_t sts,
  output dpw_cmd_t      cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EVAL  = 2'd1;
  localparam logic [1:0] S_CHECK = 2'd2;
  localparam logic [1:0] S_SEND  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       res_valid_next;
  logic       out_free;

  assign pkt_stall = (state != S_IDLE);
  assign out_free  = !res_valid || !res_stall;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (pkt_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.evaluate = 1'b1;
        state_next   = sts.stale ? S_SEND : S_CHECK;
      end
      S_CHECK: begin
        cmd.check  = 1'b1;
        state_next = S_SEND;
      end
      S_SEND: begin
        if (out_free) begin
          cmd.publish = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    res_valid_next = res_valid;
    if (cmd.publish) begin
      res_valid_next = 1'b1;
    end else if (res_valid && !res_stall) begin
      res_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      res_valid <= res_valid_next;
    end
  end

endmodule
`default_nettype wire

// File: src/dpw_datapath.sv
// Window registers, seen-mask table with per-entry valid bits, and result register.
`default_nettype none
module dpw_datapath
  import dpw_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [ID_W-1:0]   blk_id,
  input  wire logic [CNT_W-1:0]  packet_counter,
  input  wire dpw_cmd_t          cmd,
  output dpw_sts_t               sts,
  output logic [STAT_W-1:0]      status
);

  logic [MASK_W-1:0]      mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] valid_bits;

  logic [ID_W-1:0]   id_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [ID_W-1:0]   oldest_id;
  logic [SLOT_W-1:0] oldest_slot;
  logic [SLOT_W-1:0] idx_q;
  logic [MASK_W-1:0] rd_mask;
  logic [STAT_W-1:0] res;

  logic [ID_W-1:0]   back;
  logic [ID_W-1:0]   ahead;
  logic [ID_W-1:0]   move;
  logic [ID_W-1:0]   slot_sum;
  logic [SLOT_W-1:0] new_slot;
  logic [SLOT_W-1:0] idx;
  logic              slide;
  logic [MASK_W-1:0] cur_mask;
  logic [MASK_W-1:0] bit_sel;
  logic              hit;

  always_comb begin
    back      = oldest_id - id_q;
    sts.stale = !back[ID_W-1];
    ahead     = id_q - oldest_id;
    slide     = (ahead >= ID_W'(TABLE_DEPTH));
    move      = ahead - ID_W'(NEWEST_OFFSET);
    slot_sum  = ID_W'(oldest_slot) + move;
    new_slot  = slot_sum[SLOT_W-1:0];
    idx       = slide ? (new_slot + SLOT_W'(NEWEST_OFFSET))
                      : (oldest_slot + ahead[SLOT_W-1:0]);
    cur_mask  = valid_bits[idx_q] ? rd_mask : '0;
    bit_sel   = MASK_W'(1) << cnt_q;
    hit       = cur_mask[cnt_q];
  end

  // Control state: window origin and entry valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      oldest_id   <= '0;
      oldest_slot <= '0;
      valid_bits  <= '0;
    end else if (cmd.evaluate) begin
      if (sts.stale) begin
        oldest_id   <= id_q - ID_W'(TABLE_DEPTH / 2);
        oldest_slot <= '0;
        valid_bits  <= '0;
      end else if (slide) begin
        oldest_id         <= oldest_id + move;
        oldest_slot       <= new_slot;
        valid_bits[idx]   <= 1'b0;
      end
    end else if (cmd.check && !hit) begin
      valid_bits[idx_q] <= 1'b1;
    end
  end

  // Table port: registered read on evaluate, write back on a check that misses.
  always_ff @(posedge clk) begin
    if (cmd.evaluate) begin
      rd_mask <= mem[idx];
    end
    if (cmd.check && !hit) begin
      mem[idx_q] <= cur_mask | bit_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      id_q  <= blk_id;
      cnt_q <= packet_counter;
    end
    if (cmd.evaluate) begin
      idx_q <= idx;
      if (sts.stale) begin
        res <= STAT_STALE;
      end
    end
    if (cmd.check) begin
      res <= hit ? STAT_DUP : STAT_NEW;
    end
    if (cmd.publish) begin
      status <= res;
    end
  end

endmodule
`default_nettype wire

// File: src/duplicate_packet_window_unit.sv
// Top level of the duplicate packet window: replay check over a ring of per-block seen masks.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+---------------------------------
//   pkt     | in        | pkt_valid/pkt_stall  | blk_id[15:0], packet_counter[5:0]
//   res     | out       | res_valid/res_stall  | status[1:0]
//
// An item holds the block through accept and capture, window compare with table read,
// mask test with write back, and result load; a stale block skips the mask test.
// The order is set by the single table port, read then written on one entry.
// Reset is synchronous; it clears the window origin and the 64 per-entry valid bits
// at once, so no clearing pass is needed and the first beat is taken right after.
// A waiting result does not block the next accept; only the load of a new result
// waits for res_stall to drop.
`default_nettype none
module duplicate_packet_window_unit
  import dpw_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              pkt_valid,
  output logic                   pkt_stall,
  input  wire logic [ID_W-1:0]   blk_id,
  input  wire logic [CNT_W-1:0]  packet_counter,
  output logic                   res_valid,
  input  wire logic              res_stall,
  output logic [STAT_W-1:0]      status
);

  dpw_cmd_t cmd;
  dpw_sts_t sts;

  // Sequence one beat at a time and own both handshakes.
  dpw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .pkt_valid (pkt_valid),
    .pkt_stall (pkt_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Hold the window, the mask table and the result register.
  dpw_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .blk_id         (blk_id),
    .packet_counter (packet_counter),
    .cmd            (cmd),
    .sts            (sts),
    .status         (status)
  );

`ifndef ASSERT_OFF
  // Only one beat in flight: an accept is never followed by another at once.
  a_single_beat: assert property (@(posedge clk) disable iff (rst)
    (pkt_valid && !pkt_stall) |=> pkt_stall)
    else $error("beat accepted while previous beat in flight");

  // Commands are mutually exclusive.
  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cmd))
    else $error("more than one datapath command");

  // Mask test follows the table read of the same beat.
  a_check_order: assert property (@(posedge clk) disable iff (rst)
    cmd.check |-> $past(cmd.evaluate))
    else $error("check without preceding evaluate");

  // A loaded result is offered on the next cycle.
  a_publish_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |=> res_valid)
    else $error("published result not presented");
`endif

endmodule
`default_nettype wire
